>>> src/bmhq_pkg.sv
// Shared constants, types and codes of the binary min-heap queue.
package bmhq_pkg;

	localparam int DEPTH       = 512;
	localparam int WEIGHT_BITS = 32;
	localparam int TAG_BITS    = 16;
	localparam int LIMIT_W     = 10;
	localparam int LIMIT_RESET = 512;

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = ADDR_W + 1;
	localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	typedef logic [WEIGHT_BITS-1:0] weight_t;
	typedef logic [TAG_BITS-1:0]    tag_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [LIMIT_W-1:0]     limit_t;
	typedef logic [ADDR_W-1:0]      addr_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CMP_W-1:0]       cmp_t;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_BUILD  = 2'd1,
		CMD_INSERT = 2'd2,
		CMD_POP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		weight_t weight;
		tag_t    tag;
	} entry_t;

endpackage

>>> src/bmhq_if.sv
// Request and response channel interfaces of the binary min-heap queue.
interface bmhq_req_if;
	logic            valid;
	logic            ready;
	bmhq_pkg::cmd_t  cmd;
	bmhq_pkg::weight_t weight;
	bmhq_pkg::tag_t  tag;

	modport source (output valid, output cmd, output weight, output tag, input ready);
	modport sink   (input valid, input cmd, input weight, input tag, output ready);
endinterface

interface bmhq_rsp_if;
	logic              valid;
	logic              ready;
	bmhq_pkg::weight_t out_weight;
	bmhq_pkg::tag_t    out_tag;
	bmhq_pkg::status_t status;
	bmhq_pkg::cnt_t    count;

	modport source (output valid, output out_weight, output out_tag, output status,
		output count, input ready);
	modport sink   (input valid, input out_weight, input out_tag, input status,
		input count, output ready);
endinterface

>>> src/binary_min_heap_queue_top.sv
// Binary min-heap priority queue: one entry store, a sift-down and a sift-up comparator, a small sequencer.
// Load, a dropped append, an empty pop and a build with no parent go straight to the result;
//   insert climbs from the new slot towards the root; pop reads the root and the last entry,
//   then sifts the last entry down from the root; build sifts each parent down, last first.
//   One command at a time; the next can be taken in the same cycle the result is offered.
//   Reset: count 0, limit 512, idle, store kept.
module binary_min_heap_queue_top (
	input  logic                   clk,
	input  logic                   arst_n,
	bmhq_req_if.sink               req,
	bmhq_rsp_if.source             rsp,
	input  logic                   cfg_we,
	input  bmhq_pkg::limit_t       cfg_data
);

	// One-hot sequencer states
	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_FIN    = 12'b0000_0000_0010,
		S_POP_R0 = 12'b0000_0000_0100,
		S_POP_RL = 12'b0000_0000_1000,
		S_POP_LD = 12'b0000_0001_0000,
		S_BLD_RD = 12'b0000_0010_0000,
		S_BLD_LD = 12'b0000_0100_0000,
		S_UP_RD  = 12'b0000_1000_0000,
		S_UP_CMP = 12'b0001_0000_0000,
		S_DN_L   = 12'b0010_0000_0000,
		S_DN_R   = 12'b0100_0000_0000,
		S_DN_C   = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	// Control state
	bmhq_pkg::cnt_t   count_q;
	bmhq_pkg::limit_t limit_q;
	bmhq_pkg::cmd_t   cmd_q;
	logic             out_vld_q;

	// Datapath registers
	bmhq_pkg::entry_t  cur_q;       // entry being sifted; its slot is the hole at pos_q
	bmhq_pkg::addr_t   pos_q;
	bmhq_pkg::addr_t   bi_q;        // parent being heapified during a build
	bmhq_pkg::entry_t  lch_q;       // left child held while the right one is read
	logic              r_ok_q;
	bmhq_pkg::weight_t res_w_q;
	bmhq_pkg::tag_t    res_t_q;
	bmhq_pkg::status_t res_st_q;
	bmhq_pkg::weight_t out_w_q;
	bmhq_pkg::tag_t    out_t_q;
	bmhq_pkg::status_t out_st_q;
	bmhq_pkg::cnt_t    out_cnt_q;

	// Entry memory: one write port, one registered read port
	bmhq_pkg::entry_t heap_mem_q [bmhq_pkg::DEPTH];
	bmhq_pkg::entry_t rd_data_q;
	logic             rd_en;
	bmhq_pkg::addr_t  rd_addr;
	logic             wr_en;
	bmhq_pkg::addr_t  wr_addr;
	bmhq_pkg::entry_t wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			heap_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= heap_mem_q[rd_addr];
		end
	end

	// Capacity check: the limit saturates at the memory depth
	bmhq_pkg::cmp_t cap;
	logic           full;
	assign cap  = (bmhq_pkg::cmp_t'(limit_q) > bmhq_pkg::cmp_t'(bmhq_pkg::DEPTH))
		? bmhq_pkg::cmp_t'(bmhq_pkg::DEPTH) : bmhq_pkg::cmp_t'(limit_q);
	assign full = bmhq_pkg::cmp_t'(count_q) >= cap;

	// Tree arithmetic around the hole
	bmhq_pkg::idx_t  lidx, ridx, cnt_x;
	bmhq_pkg::addr_t parent;
	bmhq_pkg::cnt_t  cnt_m1, half_m1;
	logic            l_in, r_in;
	assign lidx    = {pos_q, 1'b1};
	assign ridx    = lidx + bmhq_pkg::idx_t'(1);
	assign cnt_x   = bmhq_pkg::idx_t'(count_q);
	assign l_in    = lidx < cnt_x;
	assign r_in    = ridx < cnt_x;
	assign parent  = (pos_q - bmhq_pkg::addr_t'(1)) >> 1;
	assign cnt_m1  = count_q - bmhq_pkg::cnt_t'(1);
	assign half_m1 = (count_q >> 1) - bmhq_pkg::cnt_t'(1);

	// Shared compare unit: pick the lightest of hole entry, left and right child.
	// Strict less-than only, so the hole wins ties and the left child beats the right.
	logic             take_l, take_r, stay;
	bmhq_pkg::weight_t best_w;
	always_comb begin
		take_l = lch_q.weight < cur_q.weight;
		best_w = take_l ? lch_q.weight : cur_q.weight;
		take_r = r_ok_q && (rd_data_q.weight < best_w);
		stay   = !take_l && !take_r;
	end

	logic accept;
	logic res_free;
	logic bld_more;
	assign accept   = req.valid && req.ready;
	assign res_free = !out_vld_q || rsp.ready;
	assign bld_more = (cmd_q == bmhq_pkg::CMD_BUILD) && (bi_q != '0);

	// Memory port steering
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = cur_q;
		case (state_q)
			S_IDLE: begin
				wr_addr = count_q[bmhq_pkg::ADDR_W-1:0];
				wr_data = '{weight: req.weight, tag: req.tag};
				wr_en   = accept && (req.cmd == bmhq_pkg::CMD_LOAD) && !full;
			end
			S_POP_R0: begin
				rd_en = 1'b1;
			end
			S_POP_RL: begin
				rd_en   = 1'b1;
				rd_addr = count_q[bmhq_pkg::ADDR_W-1:0];
			end
			S_BLD_RD: begin
				rd_en   = 1'b1;
				rd_addr = bi_q;
			end
			S_UP_RD: begin
				rd_en   = pos_q != '0;
				rd_addr = parent;
				wr_en   = pos_q == '0;
			end
			S_UP_CMP: begin
				wr_en = 1'b1;
				if (rd_data_q.weight > cur_q.weight) begin
					wr_data = rd_data_q;
				end
			end
			S_DN_L: begin
				rd_en   = l_in;
				rd_addr = lidx[bmhq_pkg::ADDR_W-1:0];
				wr_en   = !l_in;
			end
			S_DN_R: begin
				rd_en   = r_in;
				rd_addr = ridx[bmhq_pkg::ADDR_W-1:0];
			end
			S_DN_C: begin
				wr_en = 1'b1;
				if (take_r) begin
					wr_data = rd_data_q;
				end else if (take_l) begin
					wr_data = lch_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			limit_q   <= bmhq_pkg::limit_t'(bmhq_pkg::LIMIT_RESET);
			cmd_q     <= bmhq_pkg::CMD_LOAD;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			// raise the result beat when the sequencer finishes, drop it once taken
			if (state_q == S_FIN && res_free) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= req.cmd;
						case (req.cmd)
							bmhq_pkg::CMD_LOAD: begin
								if (!full) begin
									count_q <= count_q + bmhq_pkg::cnt_t'(1);
								end
								state_q <= S_FIN;
							end
							bmhq_pkg::CMD_INSERT: begin
								if (!full) begin
									count_q <= count_q + bmhq_pkg::cnt_t'(1);
									state_q <= S_UP_RD;
								end else begin
									state_q <= S_FIN;
								end
							end
							bmhq_pkg::CMD_BUILD: begin
								state_q <= ((count_q >> 1) != '0) ? S_BLD_RD : S_FIN;
							end
							bmhq_pkg::CMD_POP: begin
								if (count_q != '0) begin
									count_q <= cnt_m1;
									state_q <= S_POP_R0;
								end else begin
									state_q <= S_FIN;
								end
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_POP_R0: state_q <= S_POP_RL;
				S_POP_RL: state_q <= S_POP_LD;
				S_POP_LD: state_q <= S_DN_L;
				S_BLD_RD: state_q <= S_BLD_LD;
				S_BLD_LD: state_q <= S_DN_L;
				S_UP_RD: begin
					state_q <= (pos_q == '0) ? S_FIN : S_UP_CMP;
				end
				S_UP_CMP: begin
					state_q <= (rd_data_q.weight > cur_q.weight) ? S_UP_RD : S_FIN;
				end
				S_DN_L: begin
					if (l_in) begin
						state_q <= S_DN_R;
					end else begin
						state_q <= bld_more ? S_BLD_RD : S_FIN;
					end
				end
				S_DN_R: state_q <= S_DN_C;
				S_DN_C: begin
					if (!stay) begin
						state_q <= S_DN_L;
					end else begin
						state_q <= bld_more ? S_BLD_RD : S_FIN;
					end
				end
				S_FIN: begin
					// hold the result until the output register is free
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_w_q  <= '0;
					res_t_q  <= '0;
					cur_q    <= '{weight: req.weight, tag: req.tag};
					pos_q    <= count_q[bmhq_pkg::ADDR_W-1:0];
					bi_q     <= half_m1[bmhq_pkg::ADDR_W-1:0];
					if ((req.cmd == bmhq_pkg::CMD_LOAD || req.cmd == bmhq_pkg::CMD_INSERT)
						&& full) begin
						res_st_q <= bmhq_pkg::ST_FULL;
					end else if (req.cmd == bmhq_pkg::CMD_POP && count_q == '0) begin
						res_st_q <= bmhq_pkg::ST_EMPTY;
					end else begin
						res_st_q <= bmhq_pkg::ST_OK;
					end
				end
			end
			S_POP_RL: begin
				res_w_q <= rd_data_q.weight;
				res_t_q <= rd_data_q.tag;
			end
			S_POP_LD: begin
				cur_q <= rd_data_q;
				pos_q <= '0;
			end
			S_BLD_LD: begin
				cur_q <= rd_data_q;
				pos_q <= bi_q;
			end
			S_UP_CMP: begin
				if (rd_data_q.weight > cur_q.weight) begin
					pos_q <= parent;
				end
			end
			S_DN_L: begin
				if (!l_in && bld_more) begin
					bi_q <= bi_q - bmhq_pkg::addr_t'(1);
				end
			end
			S_DN_R: begin
				lch_q  <= rd_data_q;
				r_ok_q <= r_in;
			end
			S_DN_C: begin
				if (take_r) begin
					pos_q <= ridx[bmhq_pkg::ADDR_W-1:0];
				end else if (take_l) begin
					pos_q <= lidx[bmhq_pkg::ADDR_W-1:0];
				end else if (bld_more) begin
					bi_q <= bi_q - bmhq_pkg::addr_t'(1);
				end
			end
			S_FIN: begin
				if (res_free) begin
					out_w_q   <= res_w_q;
					out_t_q   <= res_t_q;
					out_st_q  <= res_st_q;
					out_cnt_q <= count_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Take a new command only while the sequencer is idle; a waiting result does not block it
	assign req.ready      = state_q == S_IDLE;
	assign rsp.valid      = out_vld_q;
	assign rsp.out_weight = out_w_q;
	assign rsp.out_tag    = out_t_q;
	assign rsp.status     = out_st_q;
	assign rsp.count      = out_cnt_q;

endmodule

>>> src/bmhq_checker.sv
// Port-level checker of the binary min-heap queue and its bind.
module bmhq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input bmhq_pkg::weight_t rsp_out_weight,
	input bmhq_pkg::tag_t    rsp_out_tag,
	input bmhq_pkg::status_t rsp_status,
	input bmhq_pkg::cnt_t    rsp_count
);

	// the sequencer is busy right after taking a command
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted on consecutive cycles");

	// the entry count never passes the memory depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_count <= bmhq_pkg::cnt_t'(bmhq_pkg::DEPTH))
		else $error("count above depth");

	// a pop on an empty heap returns nothing and leaves it empty
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == bmhq_pkg::ST_EMPTY
		|-> rsp_count == '0 && rsp_out_weight == '0 && rsp_out_tag == '0)
		else $error("empty pop with payload or non-zero count");

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_weight)
		&& $stable(rsp_out_tag) && $stable(rsp_status) && $stable(rsp_count))
		else $error("stalled result changed");

endmodule

bind binary_min_heap_queue_top bmhq_checker u_bmhq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_out_weight (rsp.out_weight),
	.rsp_out_tag    (rsp.out_tag),
	.rsp_status     (rsp.status),
	.rsp_count      (rsp.count)
);
